// ===== rtl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// bal_pkg
// Shared types and constants for the bounded array list: item layouts,
// command and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package bal_pkg;

  // Default sizing
  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  // Fixed field widths of the item channels
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned FoundW = 4;
  localparam int unsigned CountW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_TAIL = 3'd0,
    CMD_PUSH_HEAD = 3'd1,
    CMD_POP_TAIL  = 3'd2,
    CMD_POP_HEAD  = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_INSERT    = 3'd5,
    CMD_CLEAR     = 3'd6,
    CMD_NOP       = 3'd7
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // Operation applied by every cell in the same cycle
  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD_AT    = 2'd1,
    CELL_INSERT_AT  = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_en;
  } cell_ctrl_t;

  typedef struct packed {
    logic [CmdW-1:0]          cmd;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [FoundW-1:0] found_index;
    logic [CountW-1:0] entry_count;
  } out_item_t;

endpackage

// ===== rtl/bal_cell.sv =====
// ----------------------------------------------------------------------------
// bal_cell
// One slot of the list. Loads the broadcast value, takes its left or right
// neighbor's entry on a shift, and flags a match against the search value.
// ----------------------------------------------------------------------------
module bal_cell
  import bal_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DataWidthDef,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned INDEX      = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cell_ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0]      sel_idx_i,
  input  logic [CNT_W-1:0]      count_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic [DATA_WIDTH-1:0] left_i,
  input  logic [DATA_WIDTH-1:0] right_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic                  match_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(INDEX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  match_q;

  // Select the next entry for this slot
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_LOAD_AT: begin
        if (sel_idx_i == MyIdx) entry_d = data_i;
      end
      CELL_INSERT_AT: begin
        if (sel_idx_i == MyIdx) begin
          entry_d = data_i;
        end else if (MyIdx > sel_idx_i) begin
          entry_d = left_i;
        end
      end
      CELL_SHIFT_DOWN: entry_d = right_i;
      default:         entry_d = entry_q;
    endcase
  end

  // Entry storage; contents are undefined until written
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  // Compare only valid slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= (entry_q == data_i) && (MyCnt < count_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// ===== rtl/bal_first_match.sv =====
// ----------------------------------------------------------------------------
// bal_first_match
// Priority encoder over the registered match flags of the cells: reports
// the lowest matching index and whether any cell matched.
// ----------------------------------------------------------------------------
module bal_first_match
  import bal_pkg::*;
#(
  parameter int unsigned DEPTH = DepthDef,
  parameter int unsigned IDX_W = 4
) (
  input  logic [DEPTH-1:0] match_i,
  output logic             any_o,
  output logic [IDX_W-1:0] idx_o
);

  // Scan from the top so the lowest match wins
  always_comb begin
    idx_o = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_i[i]) idx_o = IDX_W'(i);
    end
  end

  assign any_o = |match_i;

endmodule

// ===== rtl/bounded_array_list.sv =====
// Result: the item is valid in the response state, which follows the execute
//   state entered when the command item is accepted.
// Flow: the list takes a new command item only once the previous result
//   has been taken.
// All slots shift, load or compare in one parallel cell step per item.
// Reset: entry count cleared, control idle; slot contents undefined until
//   written.
// ----------------------------------------------------------------------------
// bounded_array_list
// Bounded ordered list kept densely from index 0 in a row of cells, with
// push and pop at both ends, positional insert, find and clear.
// ----------------------------------------------------------------------------
module bounded_array_list
  import bal_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = CntW + PosW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [CmdW-1:0]       cmd_q;
  logic [DATA_WIDTH-1:0] val_q, val_in;
  logic [PosW-1:0]       pos_q;
  logic [CntW-1:0]       count_q, count_d;
  status_e               status_q, status_d;

  cell_ctrl_t            cell_ctrl;
  logic [IdxW-1:0]       sel_idx;
  logic                  full, empty, bad_pos;

  logic [DATA_WIDTH-1:0] entry [DEPTH];
  logic [DEPTH-1:0]      match;
  logic                  any_match;
  logic [IdxW-1:0]       first_idx;

  logic                  in_acc, out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Keep the low data bits of the value, zero-extend for wide storage
  if (DATA_WIDTH <= ValueW) begin : g_val_trunc
    assign val_in = in_item_i.value[DATA_WIDTH-1:0];
  end else begin : g_val_ext
    assign val_in = {{(DATA_WIDTH - ValueW){1'b0}}, in_item_i.value};
  end

  // Sequence: accept, execute, respond
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_acc) state_d = S_EXEC;
      S_EXEC: state_d = S_RESP;
      S_RESP: if (out_acc) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the command item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= in_item_i.cmd;
      val_q <= val_in;
      pos_q <= in_item_i.position;
    end
  end

  assign full    = (count_q == CntW'(DEPTH));
  assign empty   = (count_q == '0);
  assign bad_pos = (CmpW'(pos_q) >= CmpW'(count_q));

  // Decode the command into a cell step and the new count
  always_comb begin
    cell_ctrl = '{op: CELL_HOLD, cmp_en: 1'b0};
    sel_idx   = '0;
    count_d   = count_q;
    status_d  = status_q;
    if (state_q == S_EXEC) begin
      status_d = ST_OK;
      unique case (cmd_e'(cmd_q))
        CMD_PUSH_TAIL: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_ctrl.op = CELL_LOAD_AT;
            sel_idx      = IdxW'(count_q);
            count_d      = CntW'(count_q + 1'b1);
          end
        end
        CMD_PUSH_HEAD: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_ctrl.op = CELL_INSERT_AT;
            count_d      = CntW'(count_q + 1'b1);
          end
        end
        CMD_POP_TAIL: begin
          if (empty) status_d = ST_EMPTY;
          else       count_d  = CntW'(count_q - 1'b1);
        end
        CMD_POP_HEAD: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            cell_ctrl.op = CELL_SHIFT_DOWN;
            count_d      = CntW'(count_q - 1'b1);
          end
        end
        CMD_FIND: cell_ctrl.cmp_en = 1'b1;
        CMD_INSERT: begin
          if (full) begin
            status_d = ST_FULL;
          end else if (bad_pos) begin
            status_d = ST_BADPOS;
          end else begin
            cell_ctrl.op = CELL_INSERT_AT;
            sel_idx      = IdxW'(pos_q);
            count_d      = CntW'(count_q + 1'b1);
          end
        end
        CMD_CLEAR: count_d = '0;
        default:   status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Row of cells, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = entry[i+1];
    end

    bal_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .IDX_W      (IdxW),
      .CNT_W      (CntW),
      .INDEX      (i)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .sel_idx_i (sel_idx),
      .count_i   (count_q),
      .data_i    (val_q),
      .left_i    (left),
      .right_i   (right),
      .entry_o   (entry[i]),
      .match_o   (match[i])
    );
  end

  bal_first_match #(
    .DEPTH (DEPTH),
    .IDX_W (IdxW)
  ) u_first_match (
    .match_i (match),
    .any_o   (any_match),
    .idx_o   (first_idx)
  );

  // Drive the result item from registered state
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  always_comb begin
    out_item_o.entry_count = CountW'(count_q);
    out_item_o.status      = status_q;
    out_item_o.found_index = '0;
    if (cmd_e'(cmd_q) == CMD_FIND) begin
      if (any_match) begin
        out_item_o.status      = ST_OK;
        out_item_o.found_index = FoundW'(first_idx);
      end else begin
        out_item_o.status = ST_EMPTY;
      end
    end
  end

endmodule

// ===== tb/sv/bounded_array_list_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_array_list_checker
// Watches both item channels of the bounded array list, keeps its own copy
// of the list to predict every result item, and compares each accepted
// result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module bounded_array_list_checker
  import bal_pkg::*;
#(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_item_t  in_item_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_item_t out_item_i,
  output int        pending_o,
  output int        errors_o
);

  // Shadow list contents and occupancy
  logic [DATA_WIDTH-1:0] slots_q [DEPTH];
  int unsigned           fill_q;
  out_item_t             results_q [$];
  int                    err_n;

  // Apply one command to the shadow list and build the result item it yields
  function automatic out_item_t apply_command(in_item_t it);
    out_item_t             res;
    logic [63:0]           wide;
    logic [DATA_WIDTH-1:0] key;
    int unsigned           pos;
    int unsigned           i;
    bit                    hit;
    res    = '0;
    wide   = {32'b0, it.value};
    key    = wide[DATA_WIDTH-1:0];
    pos    = it.position;
    hit    = 1'b0;
    res.status = ST_OK;
    case (cmd_e'(it.cmd))
      CMD_PUSH_TAIL: begin
        if (fill_q >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slots_q[fill_q] = key;
          fill_q++;
        end
      end
      CMD_PUSH_HEAD: begin
        if (fill_q >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (i = fill_q; i > 0; i--) slots_q[i] = slots_q[i-1];
          slots_q[0] = key;
          fill_q++;
        end
      end
      CMD_POP_TAIL: begin
        if (fill_q == 0) res.status = ST_EMPTY;
        else fill_q--;
      end
      CMD_POP_HEAD: begin
        if (fill_q == 0) begin
          res.status = ST_EMPTY;
        end else begin
          for (i = 1; i < fill_q; i++) slots_q[i-1] = slots_q[i];
          fill_q--;
        end
      end
      CMD_FIND: begin
        res.status = ST_EMPTY;
        for (i = 0; i < fill_q; i++) begin
          if (!hit && slots_q[i] == key) begin
            hit             = 1'b1;
            res.status      = ST_OK;
            res.found_index = i[FoundW-1:0];
          end
        end
      end
      CMD_INSERT: begin
        // Full check takes priority over the position check
        if (fill_q >= DEPTH) begin
          res.status = ST_FULL;
        end else if (pos >= fill_q) begin
          res.status = ST_BADPOS;
        end else begin
          for (i = fill_q; i > pos; i--) slots_q[i] = slots_q[i-1];
          slots_q[pos] = key;
          fill_q++;
        end
      end
      CMD_CLEAR: fill_q = 0;
      default: ;
    endcase
    res.entry_count = fill_q[CountW-1:0];
    return res;
  endfunction

  // Check results first, then predict, so a result never meets its own command
  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      fill_q = 0;
      results_q.delete();
      err_n = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (results_q.size() == 0) begin
          $error("result item with no command waiting: %p", out_item_i);
          err_n++;
        end else begin
          want = results_q.pop_front();
          if (out_item_i.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item_i.status);
            err_n++;
          end
          if (out_item_i.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d",
                   want.found_index, out_item_i.found_index);
            err_n++;
          end
          if (out_item_i.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_item_i.entry_count);
            err_n++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) results_q.push_back(apply_command(in_item_i));
      pending_o <= results_q.size();
      errors_o  <= err_n;
    end
  end

endmodule

// ===== tb/sv/bounded_array_list_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_array_list_tb
// Drives command items into the bounded array list: a directed pass over
// empty, edge and bad-position cases, then biased random phases that fill,
// churn and drain the list under random idling on both channels. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module bounded_array_list_tb;
  import bal_pkg::*;

  localparam int unsigned RandomItems = 1000;
  localparam int unsigned QuietItems  = 150;
  localparam int unsigned PhaseLen    = 60;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned CycleLimit  = 300000;

  localparam int PhaseFill  = 0;
  localparam int PhaseMix   = 1;
  localparam int PhaseDrain = 2;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        pending;
  int        errors;
  int        cycles;
  bit        quiet;
  bit        hold_req;

  bounded_array_list dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  bounded_array_list_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    out_stall = 1'b0;
    cycles    = 0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
  end

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(cmd_e cmd, logic [31:0] value, logic [3:0] pos);
    in_item_t it;
    it.cmd      = cmd;
    it.value    = value;
    it.position = pos;
    return it;
  endfunction

  // Favor a small set of values so finds hit and duplicates occur
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 7))
        0: v = 32'h0000_0000;
        1: v = 32'h0000_0001;
        2: v = 32'hFFFF_FFFF;
        3: v = 32'h7FFF_FFFF;
        4: v = 32'h8000_0000;
        5: v = 32'h5555_5555;
        6: v = 32'hAAAA_AAAA;
        default: v = 32'h0000_002A;
      endcase
    end
    return v;
  endfunction

  // Pick a command with weights that push the list toward full, empty or neither
  function automatic cmd_e pick_cmd(int phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (phase)
      PhaseFill: begin
        if (r < 30) return CMD_PUSH_TAIL;
        if (r < 55) return CMD_PUSH_HEAD;
        if (r < 77) return CMD_INSERT;
        if (r < 89) return CMD_FIND;
        if (r < 93) return CMD_POP_TAIL;
        if (r < 97) return CMD_POP_HEAD;
        if (r < 99) return CMD_NOP;
        return CMD_CLEAR;
      end
      PhaseDrain: begin
        if (r < 30) return CMD_POP_TAIL;
        if (r < 60) return CMD_POP_HEAD;
        if (r < 75) return CMD_FIND;
        if (r < 82) return CMD_PUSH_TAIL;
        if (r < 88) return CMD_PUSH_HEAD;
        if (r < 94) return CMD_INSERT;
        if (r < 97) return CMD_NOP;
        return CMD_CLEAR;
      end
      default: begin
        if (r < 15) return CMD_PUSH_TAIL;
        if (r < 30) return CMD_PUSH_HEAD;
        if (r < 45) return CMD_POP_TAIL;
        if (r < 60) return CMD_POP_HEAD;
        if (r < 78) return CMD_FIND;
        if (r < 94) return CMD_INSERT;
        if (r < 98) return CMD_NOP;
        return CMD_CLEAR;
      end
    endcase
  endfunction

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned n;
    int          phase;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty list, both ends, extremes, bad positions, first match
    send_item(make_item(CMD_POP_TAIL, 32'h0, 4'd0));
    send_item(make_item(CMD_POP_HEAD, 32'h0, 4'd0));
    send_item(make_item(CMD_FIND, 32'h0, 4'd0));
    send_item(make_item(CMD_INSERT, 32'h1234_5678, 4'd0));
    send_item(make_item(CMD_NOP, 32'hFFFF_FFFF, 4'hF));
    send_item(make_item(CMD_PUSH_TAIL, 32'h8000_0000, 4'd0));
    send_item(make_item(CMD_PUSH_HEAD, 32'h7FFF_FFFF, 4'hF));
    send_item(make_item(CMD_PUSH_TAIL, 32'hFFFF_FFFF, 4'd0));
    send_item(make_item(CMD_INSERT, 32'h0000_0000, 4'd1));
    send_item(make_item(CMD_INSERT, 32'hFFFF_FFFF, 4'd0));
    send_item(make_item(CMD_INSERT, 32'h5555_5555, 4'd5));
    send_item(make_item(CMD_INSERT, 32'hAAAA_AAAA, 4'hF));
    send_item(make_item(CMD_FIND, 32'h7FFF_FFFF, 4'd0));
    send_item(make_item(CMD_FIND, 32'hFFFF_FFFF, 4'd0));
    send_item(make_item(CMD_FIND, 32'h8000_0000, 4'd0));
    send_item(make_item(CMD_FIND, 32'h0000_0001, 4'd0));
    send_item(make_item(CMD_POP_HEAD, 32'h0, 4'd0));
    send_item(make_item(CMD_POP_TAIL, 32'h0, 4'd0));
    send_item(make_item(CMD_CLEAR, 32'h0, 4'd0));
    send_item(make_item(CMD_FIND, 32'h0, 4'd0));
    idle($urandom_range(1, 11));

    // Random phases cycling fill, mix and drain
    for (n = 0; n < RandomItems; n++) begin
      phase = (n / PhaseLen) % 3;
      if (n == RandomItems - QuietItems) begin
        quiet = 1'b1;
      end
      // Hold results back long enough that the block backs up its input
      if (n == 300) hold_req = 1'b1;
      if (n == 600) drain_results();
      send_item(make_item(pick_cmd(phase), pick_value(), 4'($urandom_range(0, 15))));
      if (!quiet && $urandom_range(0, 5) == 0) idle($urandom_range(1, 11));
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
